>>> rtl/core/rv32i_subset_execute_core_unit_defines.svh
`ifndef RV32I_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH
`define RV32I_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the core clock, off during reset
`define RVX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rvx_pkg.sv
`timescale 1ns / 1ps

package rvx_pkg;

  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned MemWords = 16384;
  localparam int unsigned MemAw    = $clog2(MemWords);

  typedef enum logic [6:0] {
    OP_REG    = 7'h33,
    OP_IMM    = 7'h13,
    OP_BRANCH = 7'h63,
    OP_JAL    = 7'h6F,
    OP_LUI    = 7'h37,
    OP_AUIPC  = 7'h17,
    OP_LOAD   = 7'h03,
    OP_STORE  = 7'h23
  } opcode_e;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load / store width
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [31:0]      data;
  } rf_wr_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] idx;
    logic [31:0]      data;
  } dm_wr_t;

endpackage

>>> rtl/core/rvx_regfile.sv
`timescale 1ns / 1ps

module rvx_regfile (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [rvx_pkg::RegAw-1:0] rs1_i,
  input  logic [rvx_pkg::RegAw-1:0] rs2_i,
  input  rvx_pkg::rf_wr_t       wr_i,
  output logic [31:0]           rs1_data_o,
  output logic [31:0]           rs2_data_o
);
  import rvx_pkg::*;

  logic [31:0]        rf_q [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [31:0]        rs1_data_q;
  logic [31:0]        rs2_data_q;

  // an entry never written reads as zero; x0 is never written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rf_q[wr_i.addr] <= wr_i.data;
    end
  end

  // write-first: a commit in the same cycle is seen by the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.addr == rs1_i) begin
        rs1_data_q <= wr_i.data;
      end else if (valid_q[rs1_i]) begin
        rs1_data_q <= rf_q[rs1_i];
      end else begin
        rs1_data_q <= '0;
      end
      if (wr_i.en && wr_i.addr == rs2_i) begin
        rs2_data_q <= wr_i.data;
      end else if (valid_q[rs2_i]) begin
        rs2_data_q <= rf_q[rs2_i];
      end else begin
        rs2_data_q <= '0;
      end
    end
  end

  assign rs1_data_o = rs1_data_q;
  assign rs2_data_o = rs2_data_q;

endmodule

>>> rtl/core/rvx_dmem.sv
`timescale 1ns / 1ps

module rvx_dmem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [rvx_pkg::MemAw-1:0] rd_idx_i,
  input  rvx_pkg::dm_wr_t           wr_i,
  output logic [31:0]               rd_data_o,
  output logic                      busy_o
);
  import rvx_pkg::*;

  logic [31:0]      mem_q [MemWords];
  logic [31:0]      rd_data_q;
  logic             clr_busy_q;
  logic [MemAw-1:0] clr_idx_q;

  // zero sweep after reset, one word a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == MemAw'(MemWords - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  // write-first so a load right behind a committing store sees its data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.idx == rd_idx_i) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

>>> rtl/core/rv32i_subset_execute_core_unit.sv
`timescale 1ns / 1ps
// Small in-order RV32I subset core, one instruction word per transaction.
// Input channel: instruction_i with in_valid_i / in_stall_o. Output channel: one
// result per instruction (next_pc_o, reg_write_o, dest_reg_o, dest_value_o,
// branch_taken_o, mem_write_o, mem_address_o, mem_data_o, status_o) with
// out_valid_o / out_stall_i. A transaction moves when valid is high and stall low.
// Pipeline: operand read, execute, commit into the output register. A result is
// offered once it has passed the operand-read, commit-stage and output registers;
// one instruction per cycle is sustained while the output is not stalled, since
// later instructions get their operands forwarded from the commit stage.
// The PC, register file and data memory all update in instruction order.
// After reset the data memory is swept to zero, one word a cycle, during which
// in_stall_o stays high; register file and PC are zero at once.
// A stall on the output holds the result register; the pipeline behind it keeps
// filling, and in_stall_o rises once all three stages are occupied.
// Loads and stores beyond the memory read zero / are dropped.

`include "rv32i_subset_execute_core_unit_defines.svh"

module rv32i_subset_execute_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instruction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        reg_write_o,
  output logic [4:0]  dest_reg_o,
  output logic [31:0] dest_value_o,
  output logic        branch_taken_o,
  output logic        mem_write_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_data_o,
  output logic        status_o
);
  import rvx_pkg::*;

  logic        in_accept;
  logic        clr_busy;
  logic        out_adv, s2_adv, s1_adv;
  logic        s1_valid_q, s1_valid_d;
  logic        s2_valid_q, s2_valid_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] pc_q, pc_d;
  logic [31:0] s1_ir_q;
  logic [31:0] rs1_data, rs2_data;

  // execute stage
  logic [6:0]       op;
  logic [RegAw-1:0] rd;
  logic [2:0]       f3;
  logic [6:0]       f7;
  logic [31:0]      opa, opb;
  logic [31:0]      imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [31:0]      ex_npc, ex_val, ex_maddr, ex_mdata;
  logic             ex_wr, ex_taken, ex_mw, ex_bad, ex_load, ex_inrange;

  // commit stage
  logic [31:0]      s2_npc_q, s2_val_q, s2_maddr_q, s2_mdata_q;
  logic [RegAw-1:0] s2_rd_q;
  logic             s2_wr_q, s2_taken_q, s2_mw_q, s2_bad_q, s2_load_q, s2_inrange_q;
  logic [31:0]      dm_rdata, ld_data, s2_wval;
  rf_wr_t           rf_wr;
  dm_wr_t           dm_wr;

  logic [31:0]      next_pc_q, dest_value_q, mem_address_q, mem_data_q;
  logic [4:0]       dest_reg_q;
  logic             reg_write_q, branch_taken_q, mem_write_q, status_q;

  // handshake and stage occupancy
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && out_adv;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_adv);
  assign in_stall_o = clr_busy || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_adv) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      pc_q        <= pc_d;
    end
  end

  assign pc_d = s1_adv ? ex_npc : pc_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ir_q <= instruction_i;
    end
  end

  rvx_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rs1_i      (instruction_i[19:15]),
    .rs2_i      (instruction_i[24:20]),
    .wr_i       (rf_wr),
    .rs1_data_o (rs1_data),
    .rs2_data_o (rs2_data)
  );

  // the only older instruction not yet in the register file sits in the commit stage
  assign opa = (s2_valid_q && s2_wr_q && s2_rd_q == s1_ir_q[19:15]) ? s2_wval : rs1_data;
  assign opb = (s2_valid_q && s2_wr_q && s2_rd_q == s1_ir_q[24:20]) ? s2_wval : rs2_data;

  assign op    = s1_ir_q[6:0];
  assign rd    = s1_ir_q[11:7];
  assign f3    = s1_ir_q[14:12];
  assign f7    = s1_ir_q[31:25];
  assign imm_i = {{20{s1_ir_q[31]}}, s1_ir_q[31:20]};
  assign imm_s = {{20{s1_ir_q[31]}}, s1_ir_q[31:25], s1_ir_q[11:7]};
  assign imm_b = {{19{s1_ir_q[31]}}, s1_ir_q[31], s1_ir_q[7], s1_ir_q[30:25],
                  s1_ir_q[11:8], 1'b0};
  assign imm_j = {{11{s1_ir_q[31]}}, s1_ir_q[31], s1_ir_q[19:12], s1_ir_q[20],
                  s1_ir_q[30:21], 1'b0};
  assign imm_u = {s1_ir_q[31:12], 12'b0};

  always_comb begin
    ex_npc   = pc_q + 32'd4;
    ex_val   = '0;
    ex_maddr = '0;
    ex_mdata = '0;
    ex_wr    = 1'b0;
    ex_taken = 1'b0;
    ex_mw    = 1'b0;
    ex_bad   = 1'b0;
    ex_load  = 1'b0;
    unique case (opcode_e'(op))
      OP_REG: begin
        ex_wr = 1'b1;
        unique case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) begin
              ex_val = opa + opb;
            end else if (f7 == F7_ALT) begin
              ex_val = opa - opb;
            end else begin
              ex_wr  = 1'b0;
              ex_bad = 1'b1;
            end
          end
          F3_SLL:  ex_val = opa << opb[4:0];
          F3_SLT:  ex_val = {31'd0, $signed(opa) < $signed(opb)};
          F3_SLTU: ex_val = {31'd0, opa < opb};
          F3_XOR:  ex_val = opa ^ opb;
          F3_SR: begin
            if (f7 == F7_BASE) begin
              ex_val = opa >> opb[4:0];
            end else if (f7 == F7_ALT) begin
              ex_val = 32'($signed(opa) >>> opb[4:0]);
            end else begin
              ex_wr  = 1'b0;
              ex_bad = 1'b1;
            end
          end
          F3_OR:   ex_val = opa | opb;
          default: ex_val = opa & opb;
        endcase
      end
      OP_IMM: begin
        ex_wr = 1'b1;
        unique case (f3)
          F3_ADD: ex_val = opa + imm_i;
          F3_OR:  ex_val = opa | imm_i;
          F3_AND: ex_val = opa & imm_i;
          F3_SLL: ex_val = opa << s1_ir_q[24:20];
          F3_SR: begin
            // any nonzero funct7 selects the arithmetic shift
            if (f7 == F7_BASE) begin
              ex_val = opa >> s1_ir_q[24:20];
            end else begin
              ex_val = 32'($signed(opa) >>> s1_ir_q[24:20]);
            end
          end
          default: begin
            ex_wr  = 1'b0;
            ex_bad = 1'b1;
          end
        endcase
      end
      OP_BRANCH: begin
        unique case (f3)
          F3_BEQ:  ex_taken = (opa == opb);
          F3_BNE:  ex_taken = (opa != opb);
          F3_BLT:  ex_taken = ($signed(opa) < $signed(opb));
          F3_BGE:  ex_taken = !($signed(opa) < $signed(opb));
          F3_BLTU: ex_taken = (opa < opb);
          F3_BGEU: ex_taken = (opa >= opb);
          default: ex_bad   = 1'b1;
        endcase
        if (ex_taken) begin
          ex_npc = pc_q + imm_b;
        end
      end
      OP_JAL: begin
        ex_wr    = 1'b1;
        ex_val   = pc_q + 32'd4;
        ex_npc   = pc_q + imm_j;
        ex_taken = 1'b1;
      end
      OP_LUI: begin
        ex_wr  = 1'b1;
        ex_val = imm_u;
      end
      OP_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc_q + imm_u;
      end
      OP_LOAD: begin
        if (f3 == F3_WORD) begin
          ex_maddr = opa + imm_i;
          ex_wr    = 1'b1;
          ex_load  = 1'b1;
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 == F3_WORD) begin
          ex_maddr = opa + imm_s;
          ex_mdata = opb;
          ex_mw    = 1'b1;
        end else begin
          ex_bad = 1'b1;
        end
      end
      default: ex_bad = 1'b1;
    endcase
    if (rd == '0) begin
      ex_wr = 1'b0;
    end
  end

  assign ex_inrange = ex_maddr[31:2] < 30'(MemWords);

  rvx_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_adv),
    .rd_idx_i  (ex_maddr[MemAw+1:2]),
    .wr_i      (dm_wr),
    .rd_data_o (dm_rdata),
    .busy_o    (clr_busy)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_npc_q     <= ex_npc;
      s2_val_q     <= ex_val;
      s2_maddr_q   <= ex_maddr;
      s2_mdata_q   <= ex_mdata;
      s2_rd_q      <= rd;
      s2_wr_q      <= ex_wr;
      s2_taken_q   <= ex_taken;
      s2_mw_q      <= ex_mw;
      s2_bad_q     <= ex_bad;
      s2_load_q    <= ex_load;
      s2_inrange_q <= ex_inrange;
    end
  end

  // commit: register file and memory update as the result moves to the output
  assign ld_data = s2_inrange_q ? dm_rdata : '0;
  assign s2_wval = s2_load_q ? ld_data : s2_val_q;

  assign rf_wr.en   = s2_adv && s2_wr_q;
  assign rf_wr.addr = s2_rd_q;
  assign rf_wr.data = s2_wval;

  assign dm_wr.en   = s2_adv && s2_mw_q && s2_inrange_q;
  assign dm_wr.idx  = s2_maddr_q[MemAw+1:2];
  assign dm_wr.data = s2_mdata_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      next_pc_q      <= s2_npc_q;
      reg_write_q    <= s2_wr_q;
      dest_reg_q     <= s2_wr_q ? s2_rd_q : '0;
      dest_value_q   <= s2_wr_q ? s2_wval : '0;
      branch_taken_q <= s2_taken_q;
      mem_write_q    <= s2_mw_q;
      mem_address_q  <= s2_maddr_q;
      mem_data_q     <= s2_load_q ? ld_data : s2_mdata_q;
      status_q       <= s2_bad_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = next_pc_q;
  assign reg_write_o    = reg_write_q;
  assign dest_reg_o     = dest_reg_q;
  assign dest_value_o   = dest_value_q;
  assign branch_taken_o = branch_taken_q;
  assign mem_write_o    = mem_write_q;
  assign mem_address_o  = mem_address_q;
  assign mem_data_o     = mem_data_q;
  assign status_o       = status_q;

  `RVX_ASSERT_NOW(a_empty_while_clearing, clr_busy,
    !s1_valid_q && !s2_valid_q && !out_valid_q, "instruction in flight during memory sweep")
  `RVX_ASSERT_NOW(a_no_x0_write, out_valid_q && reg_write_q, dest_reg_q != '0,
    "result reports a write to x0")
  `RVX_ASSERT_NOW(a_unimpl_no_effect, out_valid_q && status_q,
    !reg_write_q && !mem_write_q && !branch_taken_q, "unimplemented instruction had an effect")
  `RVX_ASSERT_NEXT(a_commit_lands, s2_adv, out_valid_q,
    "committed instruction missing from output register")

endmodule
